// ----- rtl/core/pps_pkg.sv -----
// Shared types and constants for the preemptive priority scheduler.
package pps_pkg;

    localparam int KIND_W   = 2;
    localparam int TIME_W   = 32;
    localparam int ARR_W    = 16;
    localparam int BURST_W  = 16;
    localparam int PRIO_W   = 8;
    localparam int SLOT_W   = 4;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 104;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // one table row
    typedef struct packed {
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [BURST_W-1:0] remaining;
        logic [PRIO_W-1:0]  priority_val;
    } pps_entry_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic scan_start;
        logic scan_step;
        logic commit;
        logic calc_tat;
        logic out_load;
    } pps_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } pps_status_t;

endpackage

// ----- rtl/core/preemptive_priority_scheduler_core.sv -----
// Preemptive priority scheduler: top level joining sequencer and datapath.
// Load and clear beats are applied in IDLE as they are accepted; a tick beat
// goes through the slot scan, COMMIT, TAT and OUT to its result beat; the scan
// reads one table row per cycle from the single-read-port task RAM.
// A new beat is taken once the tick's result sits in the output register,
// so no new beat is accepted while a tick is still in progress.
// rst_n (asynchronous, active low) empties the table, zeroes time and counts;
// table contents are not cleared and are never read before being written.
module preemptive_priority_scheduler_core #(
    parameter int MAX_TASKS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // slave side: one beat per load, tick or clear
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata: arrival_time[15:0], burst_time[31:16], priority_req[39:32]
    input  logic [pps_pkg::IN_DATA_W-1:0]     s_tdata,
    // tuser: kind[1:0] (0 load, 1 tick, 2 clear)
    input  logic [pps_pkg::KIND_W-1:0]        s_tuser,

    // master side: one beat per tick
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata: selected_slot[3:0], idle[4], switched[5], finished[6],
    //        completion_time[38:7], turnaround[70:39], waiting[102:71],
    //        all_done[103]
    output logic [pps_pkg::OUT_DATA_W-1:0]    m_tdata
);

    import pps_pkg::*;

    pps_cmd_t    cmd;
    pps_status_t status;

    // sequencer: IDLE takes beats, SCAN walks the table, COMMIT updates the
    // winner and time, TAT forms turnaround, OUT waits for a free output reg
    pps_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_tvalid),
        .kind    (s_tuser),
        .s_ready (s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath holds the table RAM, running best candidate and the result reg
    pps_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

// ----- rtl/core/pps_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/pps_ctrl.sv -----
// Sequencer for the scheduler: input decode and tick phase control.
module pps_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_valid,
    input  logic [pps_pkg::KIND_W-1:0]      kind,
    output logic                            s_ready,
    input  pps_pkg::pps_status_t            status,
    output pps_pkg::pps_cmd_t               cmd
);

    import pps_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_COMMIT = 3'd2;
    localparam logic [2:0] ST_TAT    = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    unique case (kind)
                        KIND_LOAD:  cmd.load = 1'b1;
                        KIND_CLEAR: cmd.clear = 1'b1;
                        KIND_TICK:
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        default: ;  // unused kind, dropped
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_TAT;
            end
            ST_TAT:
            begin
                cmd.calc_tat = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/pps_dp.sv -----
// Scheduler datapath: task table, scan compare, time keeping, result register.
module pps_dp #(
    parameter int MAX_TASKS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pps_pkg::pps_cmd_t                 cmd,
    output pps_pkg::pps_status_t              status,
    input  logic [pps_pkg::IN_DATA_W-1:0]     in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [pps_pkg::OUT_DATA_W-1:0]    out_data
);

    import pps_pkg::*;

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TASKS);

    // input beat fields
    logic [ARR_W-1:0]   in_arrival;
    logic [BURST_W-1:0] in_burst;
    logic [PRIO_W-1:0]  in_prio;

    assign in_arrival = in_data[15:0];
    assign in_burst   = in_data[31:16];
    assign in_prio    = in_data[39:32];

    logic [CNT_W-1:0]  task_cnt_reg, task_cnt_next;
    logic [CNT_W-1:0]  done_cnt_reg, done_cnt_next;
    logic [TIME_W-1:0] time_reg, time_next;

    logic [CNT_W-1:0]  issue_cnt_reg, issue_cnt_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pend_slot_reg, pend_slot_next;

    logic              found_reg, found_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    pps_entry_t        best_reg, best_next;

    logic              prev_none_reg, prev_none_next;
    logic              prev_idle_reg, prev_idle_next;
    logic [IDX_W-1:0]  prev_slot_reg, prev_slot_next;

    logic              sw_reg, sw_next;
    logic              fin_reg, fin_next;
    logic [TIME_W-1:0] tat_reg, tat_next;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // table memory
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    pps_entry_t        ram_wdata;
    pps_entry_t        ram_rdata;
    logic [IDX_W-1:0]  ram_raddr;

    pps_ram #(
        .WIDTH ($bits(pps_entry_t)),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_raddr = issue_cnt_reg[IDX_W-1:0];

    logic              cand_ok;
    logic              do_load;
    logic [TIME_W-1:0] wt_val;
    logic [IDX_W+SLOT_W-1:0] slot_ext;

    assign do_load = cmd.load && (task_cnt_reg < CNT_MAX);
    assign cand_ok = ({{(TIME_W-ARR_W){1'b0}}, ram_rdata.arrival} <= time_reg)
                     && (ram_rdata.remaining != '0)
                     && (!found_reg || (ram_rdata.priority_val < best_reg.priority_val));
    assign wt_val  = (tat_reg >= {{(TIME_W-BURST_W){1'b0}}, best_reg.burst})
                     ? tat_reg - {{(TIME_W-BURST_W){1'b0}}, best_reg.burst}
                     : '0;
    assign slot_ext = {{SLOT_W{1'b0}}, best_idx_reg};

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = task_cnt_reg[IDX_W-1:0];
        ram_wdata = '{arrival: in_arrival, burst: in_burst,
                      remaining: in_burst, priority_val: in_prio};

        task_cnt_next  = task_cnt_reg;
        done_cnt_next  = done_cnt_reg;
        time_next      = time_reg;
        issue_cnt_next = issue_cnt_reg;
        pend_next      = 1'b0;
        pend_slot_next = pend_slot_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_next      = best_reg;
        prev_none_next = prev_none_reg;
        prev_idle_next = prev_idle_reg;
        prev_slot_next = prev_slot_reg;
        sw_next        = sw_reg;
        fin_next       = fin_reg;
        tat_next       = tat_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        if (do_load)
        begin
            ram_we        = 1'b1;
            task_cnt_next = task_cnt_reg + 1'b1;
            if (in_burst == '0)
            begin
                done_cnt_next = done_cnt_reg + 1'b1;
            end
        end

        if (cmd.clear)
        begin
            task_cnt_next  = '0;
            done_cnt_next  = '0;
            time_next      = '0;
            prev_none_next = 1'b1;
        end

        if (cmd.scan_start)
        begin
            issue_cnt_next = '0;
            found_next     = 1'b0;
        end

        // one read issued and one compare done per cycle
        if (cmd.scan_step)
        begin
            if (pend_reg && cand_ok)
            begin
                found_next    = 1'b1;
                best_idx_next = pend_slot_reg;
                best_next     = ram_rdata;
            end
            if (issue_cnt_reg != task_cnt_reg)
            begin
                pend_next      = 1'b1;
                pend_slot_next = issue_cnt_reg[IDX_W-1:0];
                issue_cnt_next = issue_cnt_reg + 1'b1;
            end
        end

        if (cmd.commit)
        begin
            if (time_reg != TIME_MAX)
            begin
                time_next = time_reg + 1'b1;
            end
            sw_next = prev_none_reg ||
                      (found_reg ? (prev_idle_reg || (prev_slot_reg != best_idx_reg))
                                 : !prev_idle_reg);
            prev_none_next = 1'b0;
            prev_idle_next = !found_reg;
            prev_slot_next = best_idx_reg;
            fin_next       = found_reg && (best_reg.remaining == BURST_W'(1));
            if (found_reg)
            begin
                ram_we              = 1'b1;
                ram_waddr           = best_idx_reg;
                ram_wdata           = best_reg;
                ram_wdata.remaining = best_reg.remaining - 1'b1;
                if (best_reg.remaining == BURST_W'(1))
                begin
                    done_cnt_next = done_cnt_reg + 1'b1;
                end
            end
        end

        if (cmd.calc_tat)
        begin
            tat_next = time_reg - {{(TIME_W-ARR_W){1'b0}}, best_reg.arrival};
        end

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {
                (done_cnt_reg >= task_cnt_reg),
                fin_reg ? wt_val : {TIME_W{1'b0}},
                fin_reg ? tat_reg : {TIME_W{1'b0}},
                time_reg,
                fin_reg,
                sw_reg,
                !found_reg,
                found_reg ? slot_ext[SLOT_W-1:0] : {SLOT_W{1'b0}}
            };
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_cnt_reg  <= '0;
            done_cnt_reg  <= '0;
            time_reg      <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            prev_none_reg <= 1'b1;
            prev_idle_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            task_cnt_reg  <= task_cnt_next;
            done_cnt_reg  <= done_cnt_next;
            time_reg      <= time_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            prev_none_reg <= prev_none_next;
            prev_idle_reg <= prev_idle_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_cnt_reg <= issue_cnt_next;
        pend_slot_reg <= pend_slot_next;
        best_idx_reg  <= best_idx_next;
        best_reg      <= best_next;
        prev_slot_reg <= prev_slot_next;
        sw_reg        <= sw_next;
        fin_reg       <= fin_next;
        tat_reg       <= tat_next;
        out_data_reg  <= out_data_next;
    end

    assign status.scan_last = (issue_cnt_reg == task_cnt_reg);
    assign status.out_free  = !out_valid_reg || out_ready;
    assign out_valid        = out_valid_reg;
    assign out_data         = out_data_reg;

endmodule

// ----- verif/tb_preemptive_priority_scheduler_core.sv -----
// Self-checking testbench for the preemptive priority scheduler core.
`timescale 1ns / 100ps

module tb_preemptive_priority_scheduler_core;

    import pps_pkg::*;

    localparam int MAX_TASKS = 16;
    localparam int CHOICE_IDLE = MAX_TASKS;     // previous tick ran nothing
    localparam int CHOICE_NONE = MAX_TASKS + 1; // no tick since reset or clear
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int MAX_GAP = 20;
    localparam int DRAIN_CYCLES = 2 * (MAX_TASKS + 4);
    localparam int RANDOM_ITEMS = 400;          // per idling phase

    // expected contents of one result beat
    typedef struct {
        logic [SLOT_W-1:0] slot;
        logic              idle;
        logic              switched;
        logic              finished;
        logic [TIME_W-1:0] done_at;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic              all_done;
    } tick_report_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic [KIND_W-1:0]      s_tuser = KIND_LOAD;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;

    // scheduler mirror: task table, clock and bookkeeping
    logic [ARR_W-1:0]   sched_arrival [MAX_TASKS];
    logic [BURST_W-1:0] sched_burst [MAX_TASKS];
    logic [BURST_W-1:0] sched_left [MAX_TASKS];
    logic [PRIO_W-1:0]  sched_prio [MAX_TASKS];
    int unsigned        sched_count;
    int unsigned        sched_done;
    logic [TIME_W-1:0]  sched_now;
    int                 last_choice;

    tick_report_t expected_ticks[$];

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int mismatches = 0;
    int beats_checked = 0;
    int effective_items = 0;
    int loads_rejected = 0;
    int kind_ignored = 0;
    int completions = 0;
    int idle_ticks = 0;
    int switches = 0;

    always #5 clk = ~clk;

    preemptive_priority_scheduler_core #(
        .MAX_TASKS (MAX_TASKS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                   input logic [TIME_W-1:0] want);
        mismatches++;
        $display("MISMATCH result beat %0d %s: got 0x%0h, expected 0x%0h",
                 beats_checked, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [TIME_W-1:0] got,
                               input logic [TIME_W-1:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Applies one accepted beat to the mirror; a tick queues its expected report.
    function automatic void apply_beat(input logic [KIND_W-1:0] kind,
                                       input logic [ARR_W-1:0] arr,
                                       input logic [BURST_W-1:0] burst,
                                       input logic [PRIO_W-1:0] prio);
        tick_report_t r;
        bit           found;
        int           best;
        int           choice;
        logic [TIME_W-1:0] tat;
        if (kind == KIND_LOAD)
        begin
            if (sched_count < MAX_TASKS)
            begin
                sched_arrival[sched_count] = arr;
                sched_burst[sched_count] = burst;
                sched_left[sched_count] = burst;
                sched_prio[sched_count] = prio;
                sched_count++;
                // zero work: done on arrival, never picked
                if (burst == '0)
                    sched_done++;
                effective_items++;
            end
            else
                loads_rejected++;
        end
        else if (kind == KIND_CLEAR)
        begin
            sched_count = 0;
            sched_done = 0;
            sched_now = '0;
            last_choice = CHOICE_NONE;
            effective_items++;
        end
        else if (kind == KIND_TICK)
        begin
            found = 1'b0;
            best = 0;
            // strict less-than keeps the lowest slot on equal priority
            for (int i = 0; i < int'(sched_count); i++)
            begin
                if (TIME_W'(sched_arrival[i]) <= sched_now && sched_left[i] != '0 &&
                    (!found || sched_prio[i] < sched_prio[best]))
                begin
                    best = i;
                    found = 1'b1;
                end
            end
            choice = found ? best : CHOICE_IDLE;
            r.switched = (choice != last_choice);
            last_choice = choice;
            // time sticks at its maximum
            if (sched_now != TIME_MAX)
                sched_now++;
            r.slot = '0;
            r.finished = 1'b0;
            r.turnaround = '0;
            r.waiting = '0;
            if (found)
            begin
                r.slot = SLOT_W'(best);
                sched_left[best]--;
                if (sched_left[best] == '0)
                begin
                    r.finished = 1'b1;
                    sched_done++;
                    tat = sched_now - TIME_W'(sched_arrival[best]);
                    r.turnaround = tat;
                    // only negative once time has saturated; clamp at zero
                    r.waiting = (tat >= TIME_W'(sched_burst[best]))
                                ? tat - TIME_W'(sched_burst[best]) : '0;
                end
            end
            r.idle = !found;
            r.done_at = sched_now;
            r.all_done = (sched_done >= sched_count);
            expected_ticks.push_back(r);
            effective_items++;
            completions += r.finished;
            idle_ticks += r.idle;
            switches += r.switched;
        end
        else
            kind_ignored++;
    endfunction

    // Offers one beat after an optional idle gap and waits for the handshake.
    task automatic send_beat(input logic [KIND_W-1:0] kind,
                             input logic [ARR_W-1:0] arr,
                             input logic [BURST_W-1:0] burst,
                             input logic [PRIO_W-1:0] prio);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            gap++;
        end
        s_tvalid <= 1'b1;
        s_tdata <= {prio, burst, arr};
        s_tuser <= kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_beat(kind, arr, burst, prio);
    endtask

    task automatic tick_once();
        send_beat(KIND_TICK, ARR_W'($urandom), BURST_W'($urandom), PRIO_W'($urandom));
    endtask

    // Empty table, idle ticks, zero work, ties, preemption, field extremes,
    // the unused kind and a clear in the middle of a run.
    task automatic test_directed();
        tick_once();                                  // empty table: idle, all done
        tick_once();                                  // idle again: no switch
        send_beat(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_beat(KIND_LOAD, 16'd0, 16'd3, 8'd255);
        send_beat(KIND_LOAD, 16'd0, 16'd0, 8'd0);     // zero work
        send_beat(KIND_LOAD, 16'hFFFF, 16'hFFFF, 8'd0); // never arrives
        send_beat(KIND_LOAD, 16'd0, 16'd1, 8'd255);   // ties with slot 0
        send_beat(KIND_LOAD, 16'd4, 16'd2, 8'd10);    // preempts at time 4
        repeat (9)
            tick_once();
        send_beat(KIND_CLEAR, 16'hFFFF, 16'hFFFF, 8'hFF);
        tick_once();                                  // first tick after clear
        send_beat(KIND_LOAD, 16'd0, 16'd1, 8'd0);
        tick_once();
        tick_once();
    endtask

    function automatic logic [ARR_W-1:0] pick_arrival();
        if ($urandom_range(99) < 5)
            return ARR_W'($urandom);
        return ARR_W'($urandom_range(12));
    endfunction

    function automatic logic [BURST_W-1:0] pick_burst();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return '0;
        if (roll < 13)
            return BURST_W'($urandom);
        return BURST_W'($urandom_range(6, 1));
    endfunction

    function automatic logic [PRIO_W-1:0] pick_prio();
        // a narrow range half the time so equal priorities are common
        if ($urandom_range(1))
            return PRIO_W'($urandom_range(3));
        return PRIO_W'($urandom);
    endfunction

    // Random job sets: clear, load a batch, then tick roughly until the work
    // runs out, with late loads, unused kinds and stray clears mixed in.
    task automatic test_random_schedule(input int n_items, input int src_pct,
                                        input int snk_pct);
        int start;
        int n_load;
        int n_ticks;
        int roll;
        int unsigned work;
        int unsigned last_arr;
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
        start = effective_items;
        while (effective_items - start < n_items)
        begin
            // skipping the clear now and then lets the table fill up
            if ($urandom_range(99) < 85)
                send_beat(KIND_CLEAR, ARR_W'($urandom), BURST_W'($urandom),
                          PRIO_W'($urandom));
            n_load = ($urandom_range(99) < 15) ? $urandom_range(20, 1)
                                               : $urandom_range(8, 1);
            repeat (n_load)
                send_beat(KIND_LOAD, pick_arrival(), pick_burst(), pick_prio());
            work = 0;
            last_arr = 0;
            for (int i = 0; i < int'(sched_count); i++)
            begin
                work += sched_left[i];
                if (sched_arrival[i] > last_arr)
                    last_arr = sched_arrival[i];
            end
            if (last_arr > sched_now)
                work += last_arr - sched_now;
            n_ticks = work + $urandom_range(3);
            if (n_ticks > 48)
                n_ticks = 48;
            repeat (n_ticks)
            begin
                roll = $urandom_range(99);
                if (roll < 4)
                    send_beat(KIND_UNUSED, ARR_W'($urandom), BURST_W'($urandom),
                              PRIO_W'($urandom));
                else if (roll < 10)
                    send_beat(KIND_LOAD, ARR_W'(sched_now + $urandom_range(4)),
                              pick_burst(), pick_prio());
                else if (roll < 12)
                    send_beat(KIND_CLEAR, ARR_W'($urandom), BURST_W'($urandom),
                              PRIO_W'($urandom));
                tick_once();
            end
        end
    endtask

    // result side: random back-pressure and per-field compare
    always @(posedge clk)
    begin : result_check
        tick_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            beats_checked++;
            if (expected_ticks.size() == 0)
                report_mismatch("beat with nothing expected", m_tdata[31:0], '0);
            else
            begin
                want = expected_ticks.pop_front();
                check_field("selected_slot", TIME_W'(m_tdata[3:0]), TIME_W'(want.slot));
                check_field("idle", TIME_W'(m_tdata[4]), TIME_W'(want.idle));
                check_field("switched", TIME_W'(m_tdata[5]), TIME_W'(want.switched));
                check_field("finished", TIME_W'(m_tdata[6]), TIME_W'(want.finished));
                check_field("completion_time", m_tdata[38:7], want.done_at);
                check_field("turnaround", m_tdata[70:39], want.turnaround);
                check_field("waiting", m_tdata[102:71], want.waiting);
                check_field("all_done", TIME_W'(m_tdata[103]), TIME_W'(want.all_done));
            end
        end
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    initial
    begin
        sched_count = 0;
        sched_done = 0;
        sched_now = '0;
        last_choice = CHOICE_NONE;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_schedule(RANDOM_ITEMS, 0, 0);
        test_random_schedule(RANDOM_ITEMS, 58, 0);
        test_random_schedule(RANDOM_ITEMS, 0, 58);
        test_random_schedule(RANDOM_ITEMS, 15, 15);

        s_tvalid <= 1'b0;
        snk_stall_pct = 0;
        while (expected_ticks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Covered %0d load/tick/clear beats, %0d result beats checked",
                 effective_items, beats_checked);
        $display("  %0d completions, %0d idle ticks, %0d switches,",
                 completions, idle_ticks, switches);
        $display("  %0d loads past full, %0d unused kinds",
                 loads_rejected, kind_ignored);
        if (mismatches == 0 && expected_ticks.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #(20_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/pps_pkg.sv
rtl/core/pps_ram.sv
rtl/core/pps_ctrl.sv
rtl/core/pps_dp.sv
rtl/core/preemptive_priority_scheduler_core.sv
verif/tb_preemptive_priority_scheduler_core.sv
